### rtl/idw_pkg.sv
// Shared types and constants for the four-nearest inverse-distance interpolator.
// Used by the controller, the datapath and the arithmetic units; depends on nothing.
package idw_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CNT_W      = 7;
  localparam int VAL_W      = 24;
  localparam int NEAREST    = 4;
  localparam int SQ_W       = 2 * VAL_W + 1;
  localparam int ROOT_W     = VAL_W + 1;
  localparam int RECIP_BITS = 32;
  localparam int W_W        = RECIP_BITS + 1;
  localparam int PROD_W     = VAL_W + W_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DEN_W      = W_W + 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_MM_RD, S_MM_UPD, S_CLAMP, S_D_RD, S_D_SQ, S_D_SQRT_GO, S_D_SQRT,
    S_D_INS, S_PICK, S_W_DIV, S_W_WAIT, S_W_MUL, S_W_ACC, S_F_DIV, S_F_WAIT, S_FIN
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic cnt_clr;
    logic cnt_inc;
    logic rd_en;
    logic mm_upd;
    logic clamp;
    logic sq_en;
    logic sqrt_start;
    logic ins;
    logic k_clr;
    logic k_inc;
    logic wdiv_start;
    logic wlatch;
    logic mul_en;
    logic acc_en;
    logic fdiv_start;
    logic res_hit;
    logic res_div;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_row;
    logic sqrt_done;
    logic div_done;
    logic hit0;
    logic k_last;
  } sts_t;

endpackage

### rtl/idw_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on idw_pkg for widths.
module idw_sqrt import idw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   value_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int STEPS = (SQ_W + 1) / 2;

  logic [SQ_W-1:0]    v_q, v_d;
  logic [SQ_W:0]      res_q, res_d;
  logic [SQ_W-1:0]    bit_q, bit_d;
  logic [$clog2(STEPS+1)-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [SQ_W:0]      trial;

  // One digit step: compare against res + bit and subtract when it fits.
  always_comb begin
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = res_q + {1'b0, bit_q};
    if (start_i) begin
      v_d    = value_i;
      res_d  = '0;
      bit_d  = SQ_W'(1) << (2 * (STEPS - 1));
      cnt_d  = ($clog2(STEPS+1))'(STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_d   = SQ_W'({1'b0, v_q} - trial);
        res_d = (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

### rtl/idw_div.sv
// Restoring divider, one quotient bit per cycle, shared by weights and final mean.
// Depends on idw_pkg for widths.
module idw_div import idw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [NUM_W-1:0]         quot_q, quot_d;
  logic [DEN_W-1:0]         rem_q, rem_d, dvs_q, dvs_d;
  logic [$clog2(NUM_W+1)-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]           trial;

  // Shift in one dividend bit and subtract the divisor when it fits.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NUM_W-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = ($clog2(NUM_W+1))'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = DEN_W'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DEN_W-1:0];
        quot_d = {quot_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/idw_ctrl.sv
// Controller state machine that sequences loads, table sweeps and weighting.
// Depends on idw_pkg for the state enum and the command and status structs.
module idw_ctrl import idw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic op_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (op_i == OP_QUERY) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_MM_RD;
          end
        end
      end
      S_MM_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_MM_UPD;
      end
      S_MM_UPD: begin
        cmd_o.mm_upd = 1'b1;
        if (sts_i.last_row) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_CLAMP;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_MM_RD;
        end
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_D_RD;
      end
      S_D_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_D_SQ;
      end
      S_D_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d     = S_D_SQRT_GO;
      end
      S_D_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_D_SQRT;
      end
      S_D_SQRT: begin
        if (sts_i.sqrt_done) begin
          state_d = S_D_INS;
        end
      end
      S_D_INS: begin
        cmd_o.ins = 1'b1;
        if (sts_i.last_row) begin
          state_d = S_PICK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_D_RD;
        end
      end
      S_PICK: begin
        cmd_o.k_clr = 1'b1;
        if (sts_i.hit0) begin
          cmd_o.res_hit = 1'b1;
          state_d       = S_FIN;
        end else begin
          state_d = S_W_DIV;
        end
      end
      S_W_DIV: begin
        cmd_o.wdiv_start = 1'b1;
        state_d          = S_W_WAIT;
      end
      S_W_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.wlatch = 1'b1;
          state_d      = S_W_MUL;
        end
      end
      S_W_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_W_ACC;
      end
      S_W_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_F_DIV;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_W_DIV;
        end
      end
      S_F_DIV: begin
        cmd_o.fdiv_start = 1'b1;
        state_d          = S_F_WAIT;
      end
      S_F_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.res_div = 1'b1;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The output register holds a result until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/idw_dp.sv
// Datapath: row table memory, bounds, distances, nearest-four list and weighted mean.
// Depends on idw_pkg, idw_sqrt and idw_div.
module idw_dp import idw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             op_i,
  input  logic [ROW_W-1:0] row_index_i,
  input  logic [VAL_W-1:0] coord_x_i,
  input  logic [VAL_W-1:0] coord_y_i,
  input  logic [VAL_W-1:0] row_value_i,
  output logic [VAL_W-1:0] interpolated_value_o,
  output logic             exact_hit_o
);

  logic [3*VAL_W-1:0] mem_q [MAX_ROWS];
  logic [3*VAL_W-1:0] rd_q;
  logic [CNT_W-1:0]   row_count_q;
  logic [ROW_W-1:0]   n_m1, cnt_q;
  logic [VAL_W-1:0]   rx, ry, rz;
  logic [VAL_W-1:0]   minx_q, maxx_q, miny_q, maxy_q, qx_q, qy_q;
  logic [VAL_W-1:0]   dx, dy;
  logic [2*VAL_W-1:0] sqx_q, sqy_q;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  top_d_q [NEAREST];
  logic [VAL_W-1:0]   top_z_q [NEAREST];
  logic               top_v_q [NEAREST];
  logic               lt [NEAREST];
  logic [1:0]         k_q;
  logic [W_W-1:0]     w_q;
  logic [PROD_W-1:0]  prod_q;
  logic [NUM_W-1:0]   num_q;
  logic [DEN_W-1:0]   den_q;
  logic               div_done;
  logic [NUM_W-1:0]   quot, div_dividend;
  logic [DEN_W-1:0]   div_divisor;
  logic [VAL_W-1:0]   res_val_q;
  logic               res_hit_q;

  // Configuration register and the index of the last row in use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      row_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (row_count_q == '0) begin
      n_m1 = '0;
    end else if (row_count_q > CNT_W'(MAX_ROWS)) begin
      n_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      n_m1 = ROW_W'(row_count_q - 1'b1);
    end
  end

  // Row table: written by load requests, read one row per access.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && op_i == OP_LOAD) begin
      mem_q[row_index_i] <= {coord_x_i, coord_y_i, row_value_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cnt_q];
    end
  end

  assign rx = rd_q[3*VAL_W-1:2*VAL_W];
  assign ry = rd_q[2*VAL_W-1:VAL_W];
  assign rz = rd_q[VAL_W-1:0];

  // Row counter for both table sweeps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Query point, column bounds and clamping.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && op_i == OP_QUERY) begin
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
    end else if (cmd_i.clamp) begin
      qx_q <= (qx_q > maxx_q) ? maxx_q : ((qx_q < minx_q) ? minx_q : qx_q);
      qy_q <= (qy_q > maxy_q) ? maxy_q : ((qy_q < miny_q) ? miny_q : qy_q);
    end
    if (cmd_i.mm_upd) begin
      minx_q <= (cnt_q == '0 || rx < minx_q) ? rx : minx_q;
      maxx_q <= (cnt_q == '0 || rx > maxx_q) ? rx : maxx_q;
      miny_q <= (cnt_q == '0 || ry < miny_q) ? ry : miny_q;
      maxy_q <= (cnt_q == '0 || ry > maxy_q) ? ry : maxy_q;
    end
  end

  // Squared axis distances, registered after the multipliers.
  assign dx = (qx_q > rx) ? qx_q - rx : rx - qx_q;
  assign dy = (qy_q > ry) ? qy_q - ry : ry - qy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sqx_q <= dx * dx;
      sqy_q <= dy * dy;
    end
  end

  idw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i ({1'b0, sqx_q} + {1'b0, sqy_q}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // Sorted list of the four nearest rows; a later row displaces only on a strictly
  // smaller distance, so ties keep the lower index.
  always_comb begin
    for (int j = 0; j < NEAREST; j++) begin
      lt[j] = !top_v_q[j] || (root < top_d_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NEAREST; j++) begin
        top_v_q[j] <= 1'b0;
      end
    end else if (cmd_i.clamp) begin
      for (int j = 0; j < NEAREST; j++) begin
        top_v_q[j] <= 1'b0;
      end
    end else if (cmd_i.ins) begin
      if (lt[0]) begin
        top_v_q[0] <= 1'b1;
      end
      for (int j = 1; j < NEAREST; j++) begin
        if (lt[j]) begin
          top_v_q[j] <= lt[j-1] ? top_v_q[j-1] : 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      if (lt[0]) begin
        top_d_q[0] <= root;
        top_z_q[0] <= rz;
      end
      for (int j = 1; j < NEAREST; j++) begin
        if (lt[j]) begin
          top_d_q[j] <= lt[j-1] ? top_d_q[j-1] : root;
          top_z_q[j] <= lt[j-1] ? top_z_q[j-1] : rz;
        end
      end
    end
  end

  // Pick counter over the selected rows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.k_clr) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + 1'b1;
    end
  end

  // Shared divider: weight 2^32 / d, then the final sum(z*w) / sum(w).
  assign div_dividend = cmd_i.wdiv_start ? (NUM_W'(1) << RECIP_BITS) : num_q;
  assign div_divisor  = cmd_i.wdiv_start ? DEN_W'(top_d_q[k_q]) : den_q;

  idw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.wdiv_start || cmd_i.fdiv_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Weight product and running sums.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wlatch) begin
      w_q <= quot[W_W-1:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= top_z_q[k_q] * w_q;
    end
    if (cmd_i.k_clr) begin
      num_q <= '0;
      den_q <= '0;
    end else if (cmd_i.acc_en) begin
      num_q <= num_q + NUM_W'(prod_q);
      den_q <= den_q + DEN_W'(w_q);
    end
  end

  // Result staging and the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_hit) begin
      res_val_q <= top_z_q[0];
      res_hit_q <= 1'b1;
    end else if (cmd_i.res_div) begin
      res_val_q <= (quot > NUM_W'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : quot[VAL_W-1:0];
      res_hit_q <= 1'b0;
    end
    if (cmd_i.out_load) begin
      interpolated_value_o <= res_val_q;
      exact_hit_o          <= res_hit_q;
    end
  end

  assign sts_o.last_row  = (cnt_q == n_m1);
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.hit0      = top_v_q[0] && (top_d_q[0] == '0);
  assign sts_o.k_last    = (k_q == 2'd3) ? 1'b1 : !top_v_q[k_q + 2'd1];

endmodule

### rtl/idw_four_nearest_interp_2d_top.sv
// Top level of the four-nearest inverse-distance interpolator.
// Depends on idw_pkg, idw_ctrl and idw_dp.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries load and query
// requests, one output channel (out_valid_o / out_stall_i) returns a result for
// each query; loads return nothing. A load writes its row as it is taken, and the
// block stays ready for the next request. A query sweeps the n rows in use twice:
// first for the column bounds, then for the distance (two multipliers, then the
// bit-serial square root of 25 steps). Each of the up to four selected rows then
// takes one weight division in the shared 58-step divider, and the final mean one
// more division; an exact hit skips the division work. One query is in flight at
// a time. The result sits in an output register, so a new request is accepted
// while an earlier result waits; a finished query holds until that register is
// free. Reset clears the control state and sets row_count to 1; the table contents
// are undefined until loaded.
module idw_four_nearest_interp_2d_top import idw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [ROW_W-1:0] row_index_i,
  input  logic [VAL_W-1:0] coord_x_i,
  input  logic [VAL_W-1:0] coord_y_i,
  input  logic [VAL_W-1:0] row_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] interpolated_value_o,
  output logic             exact_hit_o
);

  cmd_t cmd;
  sts_t sts;

  idw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  idw_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .op_i                 (op_i),
    .row_index_i          (row_index_i),
    .coord_x_i            (coord_x_i),
    .coord_y_i            (coord_y_i),
    .row_value_i          (row_value_i),
    .interpolated_value_o (interpolated_value_o),
    .exact_hit_o          (exact_hit_o)
  );

endmodule

### rtl/idw_checker.sv
// Port-level checks for the interpolator top level, attached by bind.
// Depends on idw_pkg and idw_four_nearest_interp_2d_top.
module idw_port_props import idw_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             op_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [VAL_W-1:0] interpolated_value_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(interpolated_value_o))
    else $error("result changed while stalled");

  // A query keeps the input side busy on the following cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i == OP_QUERY |=> in_stall_o)
    else $error("input ready right after a query");

  // A load leaves the input side ready on the following cycle.
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i == OP_LOAD |=> !in_stall_o)
    else $error("input stalled after a load");

endmodule

bind idw_four_nearest_interp_2d_top idw_port_props u_idw_port_props (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .op_i                 (op_i),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .interpolated_value_o (interpolated_value_o)
);
